@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module of the RTL.
// Each macro builds one labeled concurrent assertion that reports with $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/ccus_pkg.sv @@
// Package for the cycle counter to microseconds block: widths and register map.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps

package ccus_pkg;

    // Field widths
    localparam int CNT_W  = 32;   // raw counter sample and wrap count
    localparam int DIV_W  = 13;   // cycles per microsecond
    localparam int WIDE_W = 64;   // magic number, extended count, result
    localparam int HALF_W = 32;   // operand width of the shared multiplier

    // Configuration port
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 64;

    // Register index, taken from address bit 3 (registers lie 8 bytes apart)
    localparam logic REG_DIVISOR          = 1'b0;
    localparam logic REG_RECIPROCAL_MAGIC = 1'b1;

    // Position of a partial product within the 128-bit accumulator
    typedef enum logic [1:0] {
        SHIFT_0  = 2'd0,
        SHIFT_32 = 2'd1,
        SHIFT_64 = 2'd2
    } shift_t;

endpackage

@@ rtl/core/cycle_counter_to_microseconds_top.sv @@
// Cycle counter to microseconds: extends a 32-bit counter sample with a wrap count
// and divides the result by the cycles-per-microsecond divisor through a reciprocal
// multiply. Depends on ccus_pkg.
`timescale 1ns / 1ps

// Each input item is a raw sample of a free-running 32-bit cycle counter. The block
// counts wraps (a sample below the previous one), forms the 64-bit extended count
// {wrap_count, sample}, and returns it together with the count in microseconds,
// high64(ext * reciprocal_magic) lowered by one when its product with the divisor
// overshoots. All products go through one 32x32 multiplier with a registered output
// feeding a 128-bit accumulator: four partial products for the quotient estimate and
// two for the check. An accepted item passes through the multiply and check states to
// ST_FIN, or straight to ST_FIN when the divisor is 0 or 1 (bypass), and it stays in
// ST_FIN while the previous result waits unaccepted in the output register. One item
// at a time is taken; a finished result waits there while the next item is accepted.
// Software writes the divisor at address 0x0 and ceil(2^64 / divisor) at address 0x8
// while the block is idle.
module cycle_counter_to_microseconds_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccus_pkg::CNT_W-1:0]    s_tdata,   // [31:0] counter_sample
    // result item stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*ccus_pkg::WIDE_W-1:0] m_tdata,   // [63:0] time_us,
                                                     // [127:64] extended_cycles
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccus_pkg::ADDR_W-1:0]   paddr,
    input  logic [ccus_pkg::PDATA_W-1:0]  pwdata,
    output logic [ccus_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int W = ccus_pkg::WIDE_W;
    localparam int H = ccus_pkg::HALF_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_LAST,
        ST_CHK,
        ST_CHK_LAST,
        ST_FIN
    } state_t;

    // Registers
    state_t                     state_reg, state_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic [ccus_pkg::DIV_W-1:0] div_reg, div_next;
    logic [W-1:0]               magic_reg, magic_next;
    logic [ccus_pkg::CNT_W-1:0] last_reg, last_next;
    logic [ccus_pkg::CNT_W-1:0] wrap_reg, wrap_next;
    logic [W-1:0]               ext_reg, ext_next;
    logic [W-1:0]               q_reg, q_next;
    logic [2*W-1:0]             acc_reg, acc_next;
    logic [W-1:0]               prod_reg, prod_next;
    ccus_pkg::shift_t           pshift_reg, pshift_next;
    logic                       pvalid_reg, pvalid_next;
    logic                       ovalid_reg, ovalid_next;
    logic [W-1:0]               otime_reg, otime_next;
    logic [W-1:0]               oext_reg, oext_next;

    // Combinational helpers
    logic [H-1:0]     mul_a;
    logic [H-1:0]     mul_b;
    ccus_pkg::shift_t mul_shift;
    logic [W-1:0]     mul_prod;
    logic [2*W-1:0]   addend;
    logic             cfg_wr;
    logic             s_acc;
    logic             out_free;
    logic             dec;
    logic [ccus_pkg::CNT_W-1:0] wrap_inc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {oext_reg, otime_reg};
    assign wrap_inc = wrap_reg + ccus_pkg::CNT_W'(1);

    // Read back the selected register
    always_comb
    begin
        case (paddr[3])
            ccus_pkg::REG_DIVISOR:
                prdata = ccus_pkg::PDATA_W'(div_reg);
            ccus_pkg::REG_RECIPROCAL_MAGIC:
                prdata = magic_reg;
            default:
                prdata = '0;
        endcase
    end

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a     = ext_reg[H-1:0];
        mul_b     = magic_reg[H-1:0];
        mul_shift = ccus_pkg::SHIFT_0;
        if (state_reg == ST_MUL || state_reg == ST_MUL_LAST)
        begin
            case (cnt_reg)
                2'd0:
                begin
                    mul_a     = ext_reg[H-1:0];
                    mul_b     = magic_reg[H-1:0];
                    mul_shift = ccus_pkg::SHIFT_0;
                end
                2'd1:
                begin
                    mul_a     = ext_reg[H-1:0];
                    mul_b     = magic_reg[W-1:H];
                    mul_shift = ccus_pkg::SHIFT_32;
                end
                2'd2:
                begin
                    mul_a     = ext_reg[W-1:H];
                    mul_b     = magic_reg[H-1:0];
                    mul_shift = ccus_pkg::SHIFT_32;
                end
                default:
                begin
                    mul_a     = ext_reg[W-1:H];
                    mul_b     = magic_reg[W-1:H];
                    mul_shift = ccus_pkg::SHIFT_64;
                end
            endcase
        end
        else
        begin
            // q * d as two partial products
            mul_b = H'(div_reg);
            if (cnt_reg[0])
            begin
                mul_a     = q_reg[W-1:H];
                mul_shift = ccus_pkg::SHIFT_32;
            end
            else
            begin
                mul_a     = q_reg[H-1:0];
                mul_shift = ccus_pkg::SHIFT_0;
            end
        end
    end

    // Shared multiplier
    assign mul_prod = mul_a * mul_b;

    // Place the registered product in the accumulator
    always_comb
    begin
        case (pshift_reg)
            ccus_pkg::SHIFT_0:  addend = {{W{1'b0}}, prod_reg};
            ccus_pkg::SHIFT_32: addend = {{H{1'b0}}, prod_reg, {H{1'b0}}};
            ccus_pkg::SHIFT_64: addend = {prod_reg, {W{1'b0}}};
            default:            addend = '0;
        endcase
    end

    // Lower the estimate when q * d overshoots the extended count
    assign dec = (acc_reg[2*W-1:W] != '0) || (acc_reg[W-1:0] > ext_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        div_next    = div_reg;
        magic_next  = magic_reg;
        last_next   = last_reg;
        wrap_next   = wrap_reg;
        ext_next    = ext_reg;
        q_next      = q_reg;
        acc_next    = pvalid_reg ? acc_reg + addend : acc_reg;
        prod_next   = mul_prod;
        pshift_next = mul_shift;
        pvalid_next = 1'b0;
        ovalid_next = ovalid_reg && !m_tready;
        otime_next  = otime_reg;
        oext_next   = oext_reg;

        // Configuration writes
        if (cfg_wr)
        begin
            case (paddr[3])
                ccus_pkg::REG_DIVISOR:
                    div_next = pwdata[ccus_pkg::DIV_W-1:0];
                ccus_pkg::REG_RECIPROCAL_MAGIC:
                    magic_next = pwdata;
                default:
                    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    // Update wrap count and form the extended count
                    if (s_tdata < last_reg)
                    begin
                        wrap_next = wrap_inc;
                        ext_next  = {wrap_inc, s_tdata};
                    end
                    else
                    begin
                        ext_next = {wrap_reg, s_tdata};
                    end
                    last_next = s_tdata;
                    acc_next  = '0;
                    cnt_next  = '0;
                    if (div_reg <= ccus_pkg::DIV_W'(1))
                    begin
                        q_next     = (s_tdata < last_reg) ? {wrap_inc, s_tdata}
                                                          : {wrap_reg, s_tdata};
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                pvalid_next = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_MUL_LAST;
                end
            end
            ST_MUL_LAST:
            begin
                // Take the high half as the quotient estimate, restart for the check
                q_next     = acc_next[2*W-1:W];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                pvalid_next = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    state_next = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    otime_next  = dec ? q_reg - W'(1) : q_reg;
                    oext_next   = ext_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            div_reg    <= '0;
            magic_reg  <= '0;
            last_reg   <= '0;
            wrap_reg   <= '0;
            ext_reg    <= '0;
            q_reg      <= '0;
            acc_reg    <= '0;
            prod_reg   <= '0;
            pshift_reg <= ccus_pkg::SHIFT_0;
            pvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            otime_reg  <= '0;
            oext_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            div_reg    <= div_next;
            magic_reg  <= magic_next;
            last_reg   <= last_next;
            wrap_reg   <= wrap_next;
            ext_reg    <= ext_next;
            q_reg      <= q_next;
            acc_reg    <= acc_next;
            prod_reg   <= prod_next;
            pshift_reg <= pshift_next;
            pvalid_reg <= pvalid_next;
            ovalid_reg <= ovalid_next;
            otime_reg  <= otime_next;
            oext_reg   <= oext_next;
        end
    end

endmodule

@@ rtl/core/ccus_checker.sv @@
// Port-level checker for cycle_counter_to_microseconds_top, with its bind statement.
// Depends on ccus_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ccus_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [2*ccus_pkg::WIDE_W-1:0] m_tdata
);

    // One item at a time: busy right after an item is taken
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A result never appears in the cycle right after its item is taken
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n,
                 s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // A stalled result holds its value
    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))

    // A new result only follows an earlier acceptance
    `ASSERT_SAME(a_result_after_item, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind cycle_counter_to_microseconds_top ccus_checker u_ccus_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
